// ===== sv/dbf_pkg.sv =====
// Shared types and helper functions for the luma deblocking edge filter.
// Used by dbf_filter and h264_luma_deblock_edge_top. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dbf_pkg;

	// Width of the signed working values inside the filter datapath.
	localparam int unsigned WorkW = 12;

	// Boundary strength that selects the strong filter; above it behaves the same.
	localparam logic [2:0] BsStrong = 3'd4;
	localparam logic [2:0] BsNone   = 3'd0;

	typedef logic signed [WorkW-1:0] work_t;

	// One input beat: one pixel column across the edge plus filter controls.
	typedef struct packed {
		logic [7:0] p3_in;
		logic [7:0] p2_in;
		logic [7:0] p1_in;
		logic [7:0] p0_in;
		logic [7:0] q0_in;
		logic [7:0] q1_in;
		logic [7:0] q2_in;
		logic [7:0] q3_in;
		logic [2:0] strength;
		logic [7:0] alpha;
		logic [7:0] beta;
		logic [4:0] tc_base;
	} dbf_in_t;

	// One result beat: the six samples that may change and the filter flag.
	typedef struct packed {
		logic [7:0] p2_out;
		logic [7:0] p1_out;
		logic [7:0] p0_out;
		logic [7:0] q0_out;
		logic [7:0] q1_out;
		logic [7:0] q2_out;
		logic       filtered;
	} dbf_out_t;

	// Zero-extends an 8-bit sample into the signed working width.
	function automatic work_t widen(input logic [7:0] v);
		return work_t'({{(WorkW-8){1'b0}}, v});
	endfunction

	// Absolute value of a working value.
	function automatic work_t abs_w(input work_t x);
		return (x < 0) ? -x : x;
	endfunction

	// Symmetric clip of x to the range -lim..lim.
	function automatic work_t clip_sym(input work_t x, input logic [5:0] lim);
		work_t hi;
		work_t lo;
		hi = work_t'({{(WorkW-6){1'b0}}, lim});
		lo = -hi;
		if (x < lo) begin
			return lo;
		end else if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

	// Saturates a working value to the 8-bit sample range.
	function automatic logic [7:0] sat_pix(input work_t x);
		if (x < 0) begin
			return 8'd0;
		end else if (x > work_t'(255)) begin
			return 8'd255;
		end
		return x[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/dbf_filter.sv =====
// Combinational edge test, normal filter and strong filter for one column.
// Depends on dbf_pkg for the beat types and arithmetic helpers.
`timescale 1ns / 1ps
`default_nettype none

module dbf_filter (
	input  wire dbf_pkg::dbf_in_t  column,
	output dbf_pkg::dbf_out_t      result
);

	dbf_pkg::work_t p3, p2, p1, p0, q0, q1, q2, q3;
	dbf_pkg::work_t alpha_w, beta_w;
	logic           on, ap, aq, sm;
	logic [5:0]     tc0, tc;

	// Normal filter terms.
	dbf_pkg::work_t avg, dp1, dq1, dsum, delta;
	logic [7:0]     n_p1, n_q1, n_p0, n_q0;

	// Strong filter terms.
	dbf_pkg::work_t tp, tq, sp0, sp1, sp2, sq0, sq1, sq2, wp0, wq0;

	assign p3 = dbf_pkg::widen(column.p3_in);
	assign p2 = dbf_pkg::widen(column.p2_in);
	assign p1 = dbf_pkg::widen(column.p1_in);
	assign p0 = dbf_pkg::widen(column.p0_in);
	assign q0 = dbf_pkg::widen(column.q0_in);
	assign q1 = dbf_pkg::widen(column.q1_in);
	assign q2 = dbf_pkg::widen(column.q2_in);
	assign q3 = dbf_pkg::widen(column.q3_in);
	assign alpha_w = dbf_pkg::widen(column.alpha);
	assign beta_w  = dbf_pkg::widen(column.beta);

	// Edge test and side smoothness flags.
	assign on = (column.strength != dbf_pkg::BsNone) &&
		(dbf_pkg::abs_w(p0 - q0) < alpha_w) &&
		(dbf_pkg::abs_w(p1 - p0) < beta_w) &&
		(dbf_pkg::abs_w(q1 - q0) < beta_w);
	assign ap = dbf_pkg::abs_w(p2 - p0) < beta_w;
	assign aq = dbf_pkg::abs_w(q2 - q0) < beta_w;
	assign sm = dbf_pkg::abs_w(p0 - q0) < ((alpha_w >>> 2) + 12'sd2);

	// Normal filter: tc grows by one for each smooth side.
	assign tc0 = {1'b0, column.tc_base};
	assign tc  = tc0 + {5'd0, ap} + {5'd0, aq};
	assign avg = (p0 + q0 + 12'sd1) >>> 1;
	assign dp1 = (p2 + avg - (p1 <<< 1)) >>> 1;
	assign dq1 = (q2 + avg - (q1 <<< 1)) >>> 1;
	assign n_p1 = ap ? 8'(p1 + dbf_pkg::clip_sym(dp1, tc0)) : column.p1_in;
	assign n_q1 = aq ? 8'(q1 + dbf_pkg::clip_sym(dq1, tc0)) : column.q1_in;
	assign dsum  = (((q0 - p0) <<< 2) + (p1 - q1) + 12'sd4) >>> 3;
	assign delta = dbf_pkg::clip_sym(dsum, tc);
	assign n_p0  = dbf_pkg::sat_pix(p0 + delta);
	assign n_q0  = dbf_pkg::sat_pix(q0 - delta);

	// Strong filter: full smoothing where the side is flat, else a 3-tap average.
	assign tp  = p1 + p0 + q0;
	assign tq  = p0 + q0 + q1;
	assign sp0 = (p2 + (tp <<< 1) + q1 + 12'sd4) >>> 3;
	assign sp1 = (p2 + tp + 12'sd2) >>> 2;
	assign sp2 = ((p3 <<< 1) + (p2 <<< 1) + p2 + tp + 12'sd4) >>> 3;
	assign sq0 = (p1 + (tq <<< 1) + q2 + 12'sd4) >>> 3;
	assign sq1 = (tq + q2 + 12'sd2) >>> 2;
	assign sq2 = ((q3 <<< 1) + (q2 <<< 1) + q2 + tq + 12'sd4) >>> 3;
	assign wp0 = ((p1 <<< 1) + p0 + q1 + 12'sd2) >>> 2;
	assign wq0 = ((q1 <<< 1) + q0 + p1 + 12'sd2) >>> 2;

	// Select the outcome for this column.
	always_comb begin
		result.p2_out   = column.p2_in;
		result.p1_out   = column.p1_in;
		result.p0_out   = column.p0_in;
		result.q0_out   = column.q0_in;
		result.q1_out   = column.q1_in;
		result.q2_out   = column.q2_in;
		result.filtered = on;
		if (on) begin
			if (column.strength < dbf_pkg::BsStrong) begin
				result.p1_out = n_p1;
				result.q1_out = n_q1;
				result.p0_out = n_p0;
				result.q0_out = n_q0;
			end else begin
				if (sm && ap) begin
					result.p0_out = sp0[7:0];
					result.p1_out = sp1[7:0];
					result.p2_out = sp2[7:0];
				end else begin
					result.p0_out = wp0[7:0];
				end
				if (sm && aq) begin
					result.q0_out = sq0[7:0];
					result.q1_out = sq1[7:0];
					result.q2_out = sq2[7:0];
				end else begin
					result.q0_out = wq0[7:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/h264_luma_deblock_edge_top.sv =====
// Luma deblocking edge filter: one pixel column across a block edge per clock.
// A column is captured in the input register, filtered combinationally, and
// driven on the result ports with done high from the result register.
// Throughput: one column per cycle; busy is always low and the result has no stall.
// Reset (arst_n low, asynchronous) clears both valid flags; payload is not reset.
// Depends on dbf_pkg and dbf_filter.
`timescale 1ns / 1ps
`default_nettype none

module h264_luma_deblock_edge_top (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  wire dbf_pkg::dbf_in_t  column,
	output logic                   done,
	output dbf_pkg::dbf_out_t      result
);

	logic              valid_s1;
	logic              valid_s2;
	dbf_pkg::dbf_in_t  column_s1;
	dbf_pkg::dbf_out_t result_s2;
	dbf_pkg::dbf_out_t filt;

	// The datapath takes a new beat every cycle.
	assign busy = 1'b0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			column_s1 <= column;
		end
	end

	dbf_filter u_filter (
		.column (column_s1),
		.result (filt)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= filt;
		end
	end

	assign done   = valid_s2;
	assign result = result_s2;

endmodule

`default_nettype wire

// ===== sim/h264_luma_deblock_edge_top_tb.sv =====
// Self-checking testbench for the luma deblocking edge filter top level.
// Needs dbf_pkg and h264_luma_deblock_edge_top; a scoreboard class predicts every column.
`timescale 1ns / 1ps

module h264_luma_deblock_edge_top_tb;

	localparam int CycleLimit = 200000;
	localparam int RandomColumns = 750;

	// Scoreboard: predicts the filtered column for each accepted beat and checks results.
	class deblock_scoreboard;
		dbf_pkg::dbf_out_t expected_cols[$];
		int errors;
		int checked;
		int normal_cnt;
		int strong_cnt;
		int bypass_cnt;

		function new();
			errors = 0;
			checked = 0;
			normal_cnt = 0;
			strong_cnt = 0;
			bypass_cnt = 0;
		endfunction

		task report(input string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function int iabs(input int x);
			return (x < 0) ? -x : x;
		endfunction

		function int clamp(input int lo, input int hi, input int x);
			return (x < lo) ? lo : ((x > hi) ? hi : x);
		endfunction

		// Bit-exact filter for one column; shifts on int are arithmetic (floor).
		function dbf_pkg::dbf_out_t filter_column(input dbf_pkg::dbf_in_t c);
			int p3, p2, p1, p0, q0, q1, q2, q3;
			int alpha, beta, tc0, tc, avg, d, t;
			int np2, np1, np0, nq0, nq1, nq2;
			bit on, ap, aq, sm;
			dbf_pkg::dbf_out_t r;
			p3 = c.p3_in;
			p2 = c.p2_in;
			p1 = c.p1_in;
			p0 = c.p0_in;
			q0 = c.q0_in;
			q1 = c.q1_in;
			q2 = c.q2_in;
			q3 = c.q3_in;
			alpha = c.alpha;
			beta = c.beta;
			tc0 = c.tc_base;
			np2 = p2;
			np1 = p1;
			np0 = p0;
			nq0 = q0;
			nq1 = q1;
			nq2 = q2;
			on = (c.strength != dbf_pkg::BsNone) && (iabs(p0 - q0) < alpha) &&
				(iabs(p1 - p0) < beta) && (iabs(q1 - q0) < beta);
			if (on) begin
				ap = iabs(p2 - p0) < beta;
				aq = iabs(q2 - q0) < beta;
				if (c.strength < dbf_pkg::BsStrong) begin
					// Normal filter: tc clipped step, optional side sample updates.
					tc = tc0 + int'(ap) + int'(aq);
					avg = (p0 + q0 + 1) >>> 1;
					if (ap)
						np1 = p1 + clamp(-tc0, tc0, (p2 + avg - 2 * p1) >>> 1);
					if (aq)
						nq1 = q1 + clamp(-tc0, tc0, (q2 + avg - 2 * q1) >>> 1);
					d = clamp(-tc, tc, (4 * (q0 - p0) + (p1 - q1) + 4) >>> 3);
					np0 = clamp(0, 255, p0 + d);
					nq0 = clamp(0, 255, q0 - d);
				end else begin
					// Strong filter with the tighter alpha/4+2 step test.
					sm = iabs(p0 - q0) < ((alpha >>> 2) + 2);
					if (sm && ap) begin
						t = p1 + p0 + q0;
						np0 = (p2 + 2 * t + q1 + 4) >>> 3;
						np1 = (p2 + t + 2) >>> 2;
						np2 = (2 * p3 + 3 * p2 + t + 4) >>> 3;
					end else begin
						np0 = (2 * p1 + p0 + q1 + 2) >>> 2;
					end
					if (sm && aq) begin
						t = p0 + q0 + q1;
						nq0 = (p1 + 2 * t + q2 + 4) >>> 3;
						nq1 = (t + q2 + 2) >>> 2;
						nq2 = (2 * q3 + 3 * q2 + t + 4) >>> 3;
					end else begin
						nq0 = (2 * q1 + q0 + p1 + 2) >>> 2;
					end
				end
			end
			r.p2_out = np2[7:0];
			r.p1_out = np1[7:0];
			r.p0_out = np0[7:0];
			r.q0_out = nq0[7:0];
			r.q1_out = nq1[7:0];
			r.q2_out = nq2[7:0];
			r.filtered = on;
			return r;
		endfunction

		// Records an accepted input beat and queues its expected result.
		function void note_column(input dbf_pkg::dbf_in_t c);
			dbf_pkg::dbf_out_t r;
			r = filter_column(c);
			if (!r.filtered)
				bypass_cnt++;
			else if (c.strength < dbf_pkg::BsStrong)
				normal_cnt++;
			else
				strong_cnt++;
			expected_cols.push_back(r);
		endfunction

		function int pending();
			return expected_cols.size();
		endfunction

		task compare_field(input string name, input int got, input int want);
			if (got != want)
				report($sformatf("%s got %0d expected %0d", name, got, want));
		endtask

		// Compares one result beat with the oldest expected column.
		task check_result(input dbf_pkg::dbf_out_t got);
			dbf_pkg::dbf_out_t want;
			if (expected_cols.size() == 0) begin
				report("result strobe with no column outstanding");
				return;
			end
			want = expected_cols.pop_front();
			checked++;
			compare_field("p2_out", got.p2_out, want.p2_out);
			compare_field("p1_out", got.p1_out, want.p1_out);
			compare_field("p0_out", got.p0_out, want.p0_out);
			compare_field("q0_out", got.q0_out, want.q0_out);
			compare_field("q1_out", got.q1_out, want.q1_out);
			compare_field("q2_out", got.q2_out, want.q2_out);
			compare_field("filtered", got.filtered, want.filtered);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	dbf_pkg::dbf_in_t column;
	logic done;
	dbf_pkg::dbf_out_t result;
	int cycles;
	deblock_scoreboard sb;

	h264_luma_deblock_edge_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.column(column),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on total run length.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles, %0d columns still outstanding",
				cycles, sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result monitor: a strobe is only valid for the cycle that ends at this edge.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	function automatic dbf_pkg::dbf_in_t mk(input int p3, input int p2, input int p1,
			input int p0, input int q0, input int q1, input int q2, input int q3,
			input int bs, input int alpha, input int beta, input int tc);
		dbf_pkg::dbf_in_t c;
		c.p3_in = 8'(p3);
		c.p2_in = 8'(p2);
		c.p1_in = 8'(p1);
		c.p0_in = 8'(p0);
		c.q0_in = 8'(q0);
		c.q1_in = 8'(q1);
		c.q2_in = 8'(q2);
		c.q3_in = 8'(q3);
		c.strength = 3'(bs);
		c.alpha = 8'(alpha);
		c.beta = 8'(beta);
		c.tc_base = 5'(tc);
		return c;
	endfunction

	// A sample within +-spread of base, held to the pixel range.
	function automatic int near(input int base, input int spread);
		int v;
		v = base + int'($urandom_range(2 * spread)) - spread;
		return (v < 0) ? 0 : ((v > 255) ? 255 : v);
	endfunction

	// Mostly smooth columns that pass the edge test, some pure noise.
	function automatic dbf_pkg::dbf_in_t random_column();
		dbf_pkg::dbf_in_t c;
		int spread, p0, q0, bs, tc;
		if ($urandom_range(99) < 25) begin
			c = mk($urandom_range(255), $urandom_range(255), $urandom_range(255),
				$urandom_range(255), $urandom_range(255), $urandom_range(255),
				$urandom_range(255), $urandom_range(255), $urandom_range(7),
				$urandom_range(255), $urandom_range(255), $urandom_range(31));
		end else begin
			spread = 1 << (2 * $urandom_range(3));
			p0 = $urandom_range(255);
			q0 = near(p0, spread);
			bs = ($urandom_range(9) == 0) ? int'($urandom_range(7)) : int'($urandom_range(4, 1));
			tc = ($urandom_range(9) == 0) ? int'($urandom_range(31)) : int'($urandom_range(25));
			c = mk(near(p0, 2 * spread), near(p0, spread), near(p0, spread), p0, q0,
				near(q0, spread), near(q0, spread), near(q0, 2 * spread), bs,
				$urandom_range(255, spread), $urandom_range(255, spread / 2), tc);
		end
		return c;
	endfunction

	// Presents one column and holds it until the block takes the beat.
	task send_column(input dbf_pkg::dbf_in_t c, input bit may_idle);
		while (may_idle && $urandom_range(99) < 18) begin
			start <= 1'b0;
			@(posedge clk);
		end
		column <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_column(c);
	endtask

	// Stops sending until every outstanding column has come back.
	task wait_drained();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		dbf_pkg::dbf_in_t directed[$];
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		column <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, every strength, boundary thresholds and saturation corners.
		directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		directed.push_back(mk(255, 255, 255, 255, 255, 255, 255, 255,
			dbf_pkg::BsStrong, 255, 255, 31));
		directed.push_back(mk(10, 12, 14, 16, 18, 20, 22, 24, dbf_pkg::BsNone, 255, 255, 10));
		directed.push_back(mk(10, 12, 14, 16, 18, 20, 22, 24, 1, 255, 255, 0));
		directed.push_back(mk(10, 12, 14, 16, 18, 20, 22, 24, 2, 255, 255, 25));
		directed.push_back(mk(10, 12, 14, 16, 18, 20, 22, 24, 3, 255, 255, 31));
		directed.push_back(mk(10, 12, 14, 16, 18, 20, 22, 24, dbf_pkg::BsStrong, 255, 255, 5));
		directed.push_back(mk(10, 12, 14, 16, 18, 20, 22, 24, 5, 255, 255, 5));
		directed.push_back(mk(10, 12, 14, 16, 18, 20, 22, 24, 6, 40, 9, 5));
		directed.push_back(mk(10, 12, 14, 16, 18, 20, 22, 24, 7, 6, 255, 5));
		// New p0 clipped low, then new p0 clipped high.
		directed.push_back(mk(0, 0, 0, 5, 0, 200, 0, 0, 1, 255, 255, 31));
		directed.push_back(mk(255, 255, 255, 250, 255, 55, 255, 255, 2, 255, 255, 31));
		// Each edge test exactly at its threshold fails.
		directed.push_back(mk(50, 50, 50, 50, 60, 60, 60, 60, 1, 10, 20, 4));
		directed.push_back(mk(50, 50, 40, 50, 55, 55, 55, 55, 1, 20, 10, 4));
		directed.push_back(mk(50, 50, 50, 50, 55, 65, 55, 55, 1, 20, 10, 4));
		// Normal filter with neither side update, then only p1, then only q1 updated.
		directed.push_back(mk(0, 0, 100, 104, 110, 112, 255, 0, 3, 20, 8, 6));
		directed.push_back(mk(0, 101, 100, 104, 110, 112, 255, 0, 3, 20, 8, 6));
		directed.push_back(mk(0, 0, 100, 104, 110, 112, 109, 0, 3, 20, 8, 6));
		// Strong filter: tight step test passes, fails, and only one side smooth.
		directed.push_back(mk(90, 95, 98, 100, 104, 106, 108, 120, dbf_pkg::BsStrong, 40, 20, 0));
		directed.push_back(mk(90, 95, 98, 100, 112, 114, 116, 120, dbf_pkg::BsStrong, 40, 20, 0));
		directed.push_back(mk(90, 60, 98, 100, 104, 106, 108, 120, dbf_pkg::BsStrong, 40, 20, 0));
		directed.push_back(mk(90, 95, 98, 100, 104, 106, 200, 120, dbf_pkg::BsStrong, 40, 20, 0));
		foreach (directed[i])
			send_column(directed[i], 1'b1);
		wait_drained();

		// Random columns, with one stretch of back-to-back beats and one full drain.
		for (int i = 0; i < RandomColumns; i++) begin
			if (i == 500)
				wait_drained();
			send_column(random_column(), !(i >= 300 && i < 450));
		end
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Sent %0d columns: %0d normal-filtered, %0d strong-filtered, %0d unchanged.",
			sb.normal_cnt + sb.strong_cnt + sb.bypass_cnt, sb.normal_cnt, sb.strong_cnt,
			sb.bypass_cnt);
		$display("Compared %0d result beats, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
